// ===== src/tcpq_pkg.sv =====
// package: types, codes and constants of the three-class priority queue
`default_nettype none
package tcpq_pkg;

  localparam int HANDLE_BITS     = 16;
  localparam int CLASS_DEPTH_DEF = 64;
  localparam int NUM_CLASSES     = 3;
  localparam int THR_BITS        = 8;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd64;

  localparam logic [1:0] MODE_PUSH     = 2'd0;
  localparam logic [1:0] MODE_POP_ANY  = 2'd1;
  localparam logic [1:0] MODE_POP_INTL = 2'd2;

  localparam logic [1:0] CLS_INTERNAL = 2'd0;
  localparam logic [1:0] CLS_URGENT   = 2'd1;
  localparam logic [1:0] CLS_REGULAR  = 2'd2;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;

  typedef struct packed {
    logic [1:0]             mode;
    logic [HANDLE_BITS-1:0] msg_handle;
    logic                   is_internal;
    logic                   is_urgent;
  } tcpq_in_t;

  typedef struct packed {
    logic                   pop_valid;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [1:0]             popped_class;
    logic                   push_dropped;
    logic                   full_flag;
    logic                   half_full_flag;
  } tcpq_out_t;

endpackage
`default_nettype wire

// ===== src/tcpq_store.sv =====
// message store: one write port, one registered read port
`default_nettype none
module tcpq_store #(
  parameter int DEPTH  = 192,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/three_class_priority_queue.sv =====
// top level: three-class strict-priority message queue
//
// in channel (in_valid_i/in_ready_o, in_data_i) carries one operation per
// transaction: push a handle, pop from any class, or pop the internal class
// only. out channel (out_valid_o/out_ready_i, out_data_o) returns exactly one
// result per operation, in order. handles live in one synchronous store of
// 3 x CLASS_DEPTH entries; pointers and counts sit in flip-flops.
// a push, a pop that finds nothing and an unused mode load their result
// into the output register at acceptance; a returned message goes via the
// store's read register, then the output register, with no operation taken
// meanwhile. the output register holds a result while the receiver stalls;
// the next operation is still taken in the cycle that result is drained.
// reset empties all classes (no clearing pass, the store holds no valid
// bits) and sets the threshold to 64. the user writes the threshold through
// the apb port at address 0 only while the queue is idle; it is not enforced.
`default_nettype none
module three_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire tcpq_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output tcpq_out_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int TOT_W  = CNT_W + 1;
  localparam int CMP_W  = (TOT_W > THR_BITS) ? TOT_W : THR_BITS;
  localparam int MEM_D  = NUM_CLASSES * CLASS_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  logic [PTR_W-1:0]    head_q [NUM_CLASSES];
  logic [PTR_W-1:0]    head_d [NUM_CLASSES];
  logic [PTR_W-1:0]    tail_q [NUM_CLASSES];
  logic [PTR_W-1:0]    tail_d [NUM_CLASSES];
  logic [CNT_W-1:0]    cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0]    cnt_d  [NUM_CLASSES];
  logic [THR_BITS-1:0] thr_q;
  logic                busy_q;
  logic                out_valid_q;
  tcpq_out_t           out_q;
  logic [1:0]          pend_cls_q;
  logic                pend_full_q;
  logic                pend_half_q;

  logic              acc;
  logic [1:0]        push_cls;
  logic              push_ok;
  logic              is_pop;
  logic              pop_hit;
  logic [1:0]        pop_cls;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [TOT_W-1:0]  total;
  logic              full_d;
  logic              half_d;
  logic [HANDLE_BITS-1:0] rdata;
  tcpq_out_t         direct_res;
  logic              cfg_we;

  function automatic logic [ADDR_W-1:0] base_of(input logic [1:0] cls);
    logic [ADDR_W-1:0] b;
    case (cls)
      CLS_INTERNAL: b = '0;
      CLS_URGENT:   b = ADDR_W'(CLASS_DEPTH);
      default:      b = ADDR_W'(2 * CLASS_DEPTH);
    endcase
    return b;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    push_cls = in_data_i.is_internal ? CLS_INTERNAL :
               (in_data_i.is_urgent ? CLS_URGENT : CLS_REGULAR);
    push_ok  = cnt_q[push_cls] != CNT_W'(CLASS_DEPTH);
    is_pop   = (in_data_i.mode == MODE_POP_ANY) || (in_data_i.mode == MODE_POP_INTL);
    pop_hit  = 1'b0;
    pop_cls  = CLS_INTERNAL;
    if (cnt_q[CLS_INTERNAL] != '0) begin
      pop_hit = 1'b1;
    end else if (in_data_i.mode == MODE_POP_ANY && cnt_q[CLS_URGENT] != '0) begin
      pop_hit = 1'b1;
      pop_cls = CLS_URGENT;
    end else if (in_data_i.mode == MODE_POP_ANY && cnt_q[CLS_REGULAR] != '0) begin
      pop_hit = 1'b1;
      pop_cls = CLS_REGULAR;
    end
    pop_hit = pop_hit && is_pop;

    mem_we = acc && (in_data_i.mode == MODE_PUSH) && push_ok;
    mem_re = acc && pop_hit;
    waddr  = base_of(push_cls) + ADDR_W'(tail_q[push_cls]);
    raddr  = base_of(pop_cls) + ADDR_W'(head_q[pop_cls]);

    for (int i = 0; i < NUM_CLASSES; i++) begin
      head_d[i] = head_q[i];
      tail_d[i] = tail_q[i];
      cnt_d[i]  = cnt_q[i];
    end
    if (mem_we) begin
      tail_d[push_cls] = advance(tail_q[push_cls]);
      cnt_d[push_cls]  = cnt_q[push_cls] + CNT_W'(1);
    end
    if (mem_re) begin
      head_d[pop_cls] = advance(head_q[pop_cls]);
      cnt_d[pop_cls]  = cnt_q[pop_cls] - CNT_W'(1);
    end

    total  = TOT_W'(cnt_d[CLS_URGENT]) + TOT_W'(cnt_d[CLS_REGULAR]);
    full_d = CMP_W'(total) >= CMP_W'(thr_q);
    half_d = CMP_W'(total) >= CMP_W'(thr_q >> 1);

    direct_res                = '0;
    direct_res.push_dropped   = (in_data_i.mode == MODE_PUSH) && !push_ok;
    direct_res.full_flag      = full_d;
    direct_res.half_full_flag = half_d;
  end

  tcpq_store #(
    .DEPTH  (MEM_D),
    .WIDTH  (HANDLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.msg_handle),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= head_d[i];
        tail_q[i] <= tail_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
      busy_q <= mem_re;
      if ((acc && !pop_hit) || busy_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      pend_cls_q  <= pop_cls;
      pend_full_q <= full_d;
      pend_half_q <= half_d;
    end
    if (acc && !pop_hit) begin
      out_q <= direct_res;
    end else if (busy_q) begin
      out_q.pop_valid      <= 1'b1;
      out_q.popped_handle  <= rdata;
      out_q.popped_class   <= pend_cls_q;
      out_q.push_dropped   <= 1'b0;
      out_q.full_flag      <= pend_full_q;
      out_q.half_full_flag <= pend_half_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration port
  assign cfg_we = psel && penable && pwrite && (paddr == REG_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we) begin
      thr_q <= pwdata[THR_BITS-1:0];
    end
  end

  assign prdata = (paddr == REG_THRESHOLD) ? {{(32 - THR_BITS){1'b0}}, thr_q} : '0;
  assign pready = 1'b1;

  a_busy_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q && !in_ready_o)
    else $error("store read in flight while a result is held");

  a_busy_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && out_valid_o && out_data_o.pop_valid)
    else $error("pop read did not complete in one cycle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[CLS_INTERNAL] <= CNT_W'(CLASS_DEPTH)) &&
    (cnt_q[CLS_URGENT] <= CNT_W'(CLASS_DEPTH)) &&
    (cnt_q[CLS_REGULAR] <= CNT_W'(CLASS_DEPTH)))
    else $error("class count beyond depth");

  a_empty_pop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pop_valid) |->
      (out_data_o.popped_handle == '0) && (out_data_o.popped_class == CLS_INTERNAL))
    else $error("result without a message carries a handle");

endmodule
`default_nettype wire
